FILE: rtl/core/c2f_pkg.sv
// Shared types, widths and helpers for the Cartesian to Frenet converter.
// No dependencies; imported by c2f_sqrt, c2f_div and cartesian_to_frenet.
package c2f_pkg;

	localparam int CW      = 32;             // coordinate width, Q.8 metres
	localparam int MAX_WP  = 256;            // waypoint slots
	localparam int AW      = $clog2(MAX_WP); // waypoint address
	localparam int NCW     = AW + 1;         // path length / chosen index
	localparam int IDXW    = 8;              // index field of an input item
	localparam int DW      = CW + 1;         // coordinate difference
	localparam int PW      = 2 * DW;         // product of two differences
	localparam int SW      = PW + 1;         // sum of two products, signed
	localparam int RW      = PW / 2;         // integer square root
	localparam int QW      = CW + 3;         // capped quotients and sums

	localparam int SEARCH_RADIUS = 25600000; // 100000 m in Q.8
	localparam logic [PW-1:0] RADIUS_SQ = PW'(SEARCH_RADIUS) * PW'(SEARCH_RADIUS);
	// Anything at or above this value saturates the outputs anyway
	localparam logic [QW-1:0] INNER_CAP = QW'(1) << (CW + 2);

	localparam logic [NCW-1:0] MIN_PATH = NCW'(2);
	localparam logic [NCW-1:0] MAX_PATH = NCW'(MAX_WP);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic CFG_PATH_LENGTH = 1'b0;
	localparam logic CFG_S_OFFSET    = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_ZERO_LEN = 2'd1,
		STATUS_SAT      = 2'd2
	} status_t;

	typedef struct packed {
		logic                 mode;
		logic [IDXW-1:0]      index;
		logic signed [CW-1:0] x_position;
		logic signed [CW-1:0] y_position;
	} in_item_t;

	typedef struct packed {
		logic signed [CW-1:0] arc_length;
		logic signed [CW-1:0] lateral_offset;
		logic [IDXW-1:0]      segment;
		status_t              status;
	} out_item_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_SCAN_RD, ST_SCAN_SQX, ST_SCAN_SQY, ST_SCAN_CMP,
		ST_DIR_RD0, ST_DIR_RD1, ST_DIR_MX, ST_DIR_MY, ST_DIR_SIGN,
		ST_SEG_RD0, ST_SEG_RD1, ST_SEG_LX, ST_SEG_LY, ST_SEG_PX,
		ST_SEG_PY, ST_SEG_CX, ST_SEG_CY, ST_SEG_CR,
		ST_LEN, ST_LEN_W, ST_DIVP, ST_DIVP_W, ST_DIVC, ST_DIVC_W,
		ST_SUM_RD0, ST_SUM_RD1, ST_SUM_MX, ST_SUM_MY, ST_SUM_SQ, ST_SUM_W,
		ST_FIN
	} state_t;

	function automatic logic signed [DW-1:0] sdiff(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	// {flag, clamped value} for the signed CW-bit range
	function automatic logic [CW:0] saturate(input logic signed [QW+1:0] v);
		logic signed [QW+1:0] hi;
		logic signed [QW+1:0] lo;
		hi = {{(QW + 3 - CW){1'b0}}, {(CW - 1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return {1'b1, hi[CW-1:0]};
		else if (v < lo)
			return {1'b1, lo[CW-1:0]};
		else
			return {1'b0, v[CW-1:0]};
	endfunction

endpackage

FILE: rtl/core/c2f_sqrt.sv
// Iterative integer square root, two radicand bits per cycle, rounded to nearest.
// Depends on c2f_pkg for widths.
module c2f_sqrt import c2f_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] radicand,
	output logic          done,
	output logic [RW:0]   root
);
	localparam int REMW = RW + 4;
	localparam int CNTW = $clog2(RW + 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW-1:0]   v_q;
	logic [REMW-1:0] rem_q, rem_sh, trial, rem_nx;
	logic [RW-1:0]   r_q, r_nx;
	logic [RW:0]     root_q;

	always_comb begin
		rem_sh = {rem_q[REMW-3:0], v_q[PW-1 -: 2]};
		trial  = REMW'({r_q, 2'b01});
		if (rem_sh >= trial) begin
			rem_nx = rem_sh - trial;
			r_nx   = {r_q[RW-2:0], 1'b1};
		end else begin
			rem_nx = rem_sh;
			r_nx   = {r_q[RW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			rem_q <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			v_q   <= v_q << 2;
			rem_q <= rem_nx;
			r_q   <= r_nx;
			// remainder above the root means the true root lies past the half step
			if (cnt_q == CNTW'(1))
				root_q <= (rem_nx > REMW'(r_nx)) ? {1'b0, r_nx} + 1'b1 : {1'b0, r_nx};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/core/c2f_div.sv
// Restoring divider, one quotient bit per cycle: round_half_up(num / den), capped.
// Depends on c2f_pkg for widths and the cap.
module c2f_div import c2f_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] num,
	input  logic [RW:0]   den,
	output logic          done,
	output logic [QW-1:0] quot
);
	localparam int NUMW = PW + 2;
	localparam int DVW  = RW + 2;
	localparam int REMW = RW + 3;
	localparam int CNTW = $clog2(NUMW + 1);

	logic            busy_q, done_q, ge;
	logic [CNTW-1:0] cnt_q;
	logic [NUMW-1:0] n_q, q_q, q_nx;
	logic [DVW-1:0]  dv_q;
	logic [REMW-1:0] rem_q, rem_sh, rem_nx;
	logic [QW-1:0]   quot_q;

	always_comb begin
		rem_sh = {rem_q[REMW-2:0], n_q[NUMW-1]};
		ge     = rem_sh >= REMW'(dv_q);
		rem_nx = ge ? rem_sh - REMW'(dv_q) : rem_sh;
		q_nx   = {q_q[NUMW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// (2*num + den) / (2*den) gives the half-up rounding
			n_q   <= NUMW'({num, 1'b0}) + NUMW'(den);
			dv_q  <= {den, 1'b0};
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			rem_q <= rem_nx;
			q_q   <= q_nx;
			if (cnt_q == CNTW'(1))
				quot_q <= (q_nx >= NUMW'(INNER_CAP)) ? INNER_CAP : q_nx[QW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: rtl/core/cartesian_to_frenet.sv
// Cartesian to Frenet converter over a stored polyline of up to 256 waypoints.
// A load transaction writes one waypoint. A query's duration grows with the path length n and
// the chosen index k; it is set by the waypoint scan (read, square x, square y, compare per
// waypoint), the square root (segment length and each summed segment) and divider (run twice).
// One query in flight; a zero-length segment skips the root and both divisions.
// arst_n clears control, path_length to 2 and s_offset to 0; waypoints are not cleared.
module cartesian_to_frenet import c2f_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  in_item_t      in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output out_item_t     out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [CW-1:0] cfg_data
);
	state_t state_q, state_d;

	logic [CW-1:0] mem_x [MAX_WP];
	logic [CW-1:0] mem_y [MAX_WP];
	logic signed [CW-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0] rd_addr;

	logic [NCW-1:0] path_q, n_q, n_in, k_q, kk, k_next;
	logic signed [CW-1:0] s_off_q, x_q, y_q, pa_x_q, pa_y_q;
	logic [AW-1:0] j_q, c_q;
	logic [PW-1:0] best_q, l2_q;
	logic signed [DW-1:0] dy_q, qy_q, lx_q, ly_q, qx_q, ma, mb;
	logic signed [DW-1:0] dx_q_rd, dy_q_rd, dx_rd_pa, dy_rd_pa, qx_pa, qy_pa;
	logic signed [PW-1:0] p_q, acc_q;
	logic signed [SW-1:0] pd_q, cr_q, sum_ap, diff_ap, pd_abs_w, cr_abs_w;
	logic [RW:0] len_q;
	logic [QW-1:0] proj_q, latm_q, sum_q;
	logic [QW:0] sum_nx;
	logic zero_q, c_nz, cr_pos, in_acc, wr_en, out_free, out_load, out_valid_q;

	logic sq_start, sq_done, dv_start, dv_done;
	logic [PW-1:0] sq_in, dv_num;
	logic [RW:0] sq_root;
	logic [QW-1:0] dv_quot;

	logic signed [QW+1:0] arc_w, lat_w;
	logic [CW:0] arc_sat, lat_sat;
	out_item_t out_q, res;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign wr_en    = in_acc && (in_data.mode == MODE_LOAD);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_FIN) && out_free;

	// Waypoint memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[in_data.index[AW-1:0]] <= in_data.x_position;
			mem_y[in_data.index[AW-1:0]] <= in_data.y_position;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	always_comb begin
		n_in = (path_q < MIN_PATH) ? MIN_PATH : ((path_q > MAX_PATH) ? MAX_PATH : path_q);
		dx_q_rd  = sdiff(x_q, rd_x_q);
		dy_q_rd  = sdiff(y_q, rd_y_q);
		dx_rd_pa = sdiff(rd_x_q, pa_x_q);
		dy_rd_pa = sdiff(rd_y_q, pa_y_q);
		qx_pa    = sdiff(x_q, pa_x_q);
		qy_pa    = sdiff(y_q, pa_y_q);
		sum_ap   = SW'(acc_q) + SW'(p_q);
		diff_ap  = SW'(acc_q) - SW'(p_q);
		pd_abs_w = pd_q[SW-1] ? -pd_q : pd_q;
		cr_abs_w = cr_q[SW-1] ? -cr_q : cr_q;
		c_nz     = (c_q != '0);
		// step on when the point lies ahead of the nearest waypoint
		kk       = sum_ap[SW-1] ? {1'b0, c_q} : {1'b0, c_q} + 1'b1;
		k_next   = (kk >= n_q) ? n_q - 1'b1 : kk;
		cr_pos   = !cr_q[SW-1] && (cr_q != '0);
		sum_nx   = {1'b0, sum_q} + (QW + 1)'(sq_root);
	end

	always_comb begin
		arc_w = $signed({2'b00, sum_q}) + $signed({2'b00, proj_q}) + (QW + 2)'(s_off_q);
		lat_w = cr_pos ? $signed({2'b00, latm_q}) : -$signed({2'b00, latm_q});
		arc_sat = saturate(arc_w);
		lat_sat = saturate(lat_w);
		res.arc_length     = arc_sat[CW-1:0];
		res.lateral_offset = lat_sat[CW-1:0];
		res.segment        = k_q[IDXW-1:0];
		if (arc_sat[CW] || lat_sat[CW])
			res.status = STATUS_SAT;
		else if (zero_q)
			res.status = STATUS_ZERO_LEN;
		else
			res.status = STATUS_OK;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_acc && in_data.mode == MODE_QUERY) state_d = ST_SCAN_RD;
			ST_SCAN_RD:  state_d = ST_SCAN_SQX;
			ST_SCAN_SQX: state_d = ST_SCAN_SQY;
			ST_SCAN_SQY: state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: state_d = ({1'b0, j_q} == n_q - 1'b1) ? ST_DIR_RD0 : ST_SCAN_RD;
			ST_DIR_RD0:  state_d = ST_DIR_RD1;
			ST_DIR_RD1:  state_d = ST_DIR_MX;
			ST_DIR_MX:   state_d = ST_DIR_MY;
			ST_DIR_MY:   state_d = ST_DIR_SIGN;
			ST_DIR_SIGN: state_d = (k_next == '0) ? ST_FIN : ST_SEG_RD0;
			ST_SEG_RD0:  state_d = ST_SEG_RD1;
			ST_SEG_RD1:  state_d = ST_SEG_LX;
			ST_SEG_LX:   state_d = ST_SEG_LY;
			ST_SEG_LY:   state_d = ST_SEG_PX;
			ST_SEG_PX:   state_d = ST_SEG_PY;
			ST_SEG_PY:   state_d = ST_SEG_CX;
			ST_SEG_CX:   state_d = ST_SEG_CY;
			ST_SEG_CY:   state_d = ST_SEG_CR;
			ST_SEG_CR:   state_d = (l2_q == '0) ? ST_SUM_RD0 : ST_LEN;
			ST_LEN:      state_d = ST_LEN_W;
			ST_LEN_W:    if (sq_done) state_d = ST_DIVP;
			ST_DIVP:     state_d = ST_DIVP_W;
			ST_DIVP_W:   if (dv_done) state_d = ST_DIVC;
			ST_DIVC:     state_d = ST_DIVC_W;
			ST_DIVC_W:   if (dv_done) state_d = ST_SUM_RD0;
			ST_SUM_RD0:  state_d = (k_q < NCW'(2)) ? ST_FIN : ST_SUM_RD1;
			ST_SUM_RD1:  state_d = ST_SUM_MX;
			ST_SUM_MX:   state_d = ST_SUM_MY;
			ST_SUM_MY:   state_d = ST_SUM_SQ;
			ST_SUM_SQ:   state_d = ST_SUM_W;
			ST_SUM_W: begin
				if (sq_done)
					state_d = ({1'b0, j_q} == k_q - 1'b1) ? ST_FIN : ST_SUM_MX;
			end
			ST_FIN:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory address, multiplier operands and unit starts
	always_comb begin
		rd_addr  = j_q;
		ma       = '0;
		mb       = '0;
		sq_start = 1'b0;
		sq_in    = l2_q;
		dv_start = 1'b0;
		dv_num   = pd_abs_w[PW-1:0];
		unique case (state_q)
			ST_SCAN_SQX: begin
				ma = dx_q_rd;
				mb = dx_q_rd;
			end
			ST_SCAN_SQY, ST_SUM_MY: begin
				ma = dy_q;
				mb = dy_q;
			end
			ST_DIR_RD0:  rd_addr = c_nz ? c_q - 1'b1 : '0;
			ST_DIR_RD1:  rd_addr = c_nz ? c_q : AW'(1);
			ST_DIR_MX: begin
				ma = dx_rd_pa;
				mb = c_nz ? dx_q_rd : qx_pa;
			end
			ST_DIR_MY: begin
				ma = dy_q;
				mb = qy_q;
			end
			ST_SEG_RD0:  rd_addr = k_q[AW-1:0] - 1'b1;
			ST_SEG_RD1:  rd_addr = k_q[AW-1:0];
			ST_SEG_LX, ST_SUM_MX: begin
				ma = dx_rd_pa;
				mb = dx_rd_pa;
			end
			ST_SEG_LY: begin
				ma = ly_q;
				mb = ly_q;
			end
			ST_SEG_PX: begin
				ma = qx_q;
				mb = lx_q;
			end
			ST_SEG_PY: begin
				ma = qy_q;
				mb = ly_q;
			end
			ST_SEG_CX: begin
				ma = qx_q;
				mb = ly_q;
			end
			ST_SEG_CY: begin
				ma = lx_q;
				mb = qy_q;
			end
			ST_LEN:      sq_start = 1'b1;
			ST_DIVP:     dv_start = 1'b1;
			ST_DIVC: begin
				dv_start = 1'b1;
				dv_num   = cr_abs_w[PW-1:0];
			end
			ST_SUM_RD0:  rd_addr = '0;
			ST_SUM_RD1:  rd_addr = AW'(1);
			ST_SUM_SQ: begin
				sq_start = 1'b1;
				sq_in    = sum_ap[PW-1:0];
			end
			ST_SUM_W:    rd_addr = j_q + 1'b1;
			default: ;
		endcase
	end

	c2f_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_in),
		.done     (sq_done),
		.root     (sq_root)
	);

	c2f_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (len_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			path_q      <= MIN_PATH;
			s_off_q     <= '0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PATH_LENGTH)
					path_q <= cfg_data[NCW-1:0];
				else
					s_off_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		p_q <= ma * mb;
		if (out_load)
			out_q <= res;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					x_q    <= in_data.x_position;
					y_q    <= in_data.y_position;
					n_q    <= n_in;
					j_q    <= '0;
					c_q    <= '0;
					k_q    <= '0;
					best_q <= RADIUS_SQ;
					sum_q  <= '0;
					proj_q <= '0;
					latm_q <= '0;
					zero_q <= 1'b0;
					cr_q   <= '0;
				end
			end
			ST_SCAN_SQX: dy_q <= dy_q_rd;
			ST_SCAN_CMP: begin
				// strict compare keeps the first of equal minima
				if (sum_ap[PW-1:0] < best_q) begin
					best_q <= sum_ap[PW-1:0];
					c_q    <= j_q;
				end
				j_q <= j_q + 1'b1;
			end
			ST_DIR_RD1, ST_SEG_RD1: begin
				pa_x_q <= rd_x_q;
				pa_y_q <= rd_y_q;
			end
			ST_DIR_MX: begin
				dy_q <= dy_rd_pa;
				qy_q <= c_nz ? dy_q_rd : qy_pa;
			end
			ST_SCAN_SQY, ST_DIR_MY, ST_SEG_LY, ST_SEG_PY, ST_SEG_CY, ST_SUM_MY:
				acc_q <= p_q;
			ST_DIR_SIGN: k_q <= k_next;
			ST_SEG_LX: begin
				lx_q <= dx_rd_pa;
				ly_q <= dy_rd_pa;
				qx_q <= qx_pa;
				qy_q <= qy_pa;
			end
			ST_SEG_PX: l2_q <= sum_ap[PW-1:0];
			ST_SEG_CX: pd_q <= sum_ap;
			ST_SEG_CR: begin
				cr_q   <= diff_ap;
				zero_q <= (l2_q == '0);
			end
			ST_LEN_W:  if (sq_done) len_q <= sq_root;
			ST_DIVP_W: if (dv_done) proj_q <= dv_quot;
			ST_DIVC_W: if (dv_done) latm_q <= dv_quot;
			ST_SUM_RD1: begin
				pa_x_q <= rd_x_q;
				pa_y_q <= rd_y_q;
				j_q    <= '0;
			end
			ST_SUM_MX: begin
				pa_x_q <= rd_x_q;
				pa_y_q <= rd_y_q;
				dy_q   <= dy_rd_pa;
				j_q    <= j_q + 1'b1;
			end
			ST_SUM_W: begin
				if (sq_done)
					sum_q <= (sum_nx >= (QW + 1)'(INNER_CAP)) ? INNER_CAP : sum_nx[QW-1:0];
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while holding an untaken result");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CMP) |-> ({1'b0, j_q} < n_q))
		else $error("nearest-waypoint scan ran past the path length");

	a_seg_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEG_RD0) |-> (k_q != '0 && k_q < n_q))
		else $error("projection segment index out of range");

	a_fin_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM_W && state_d == ST_FIN) |-> sq_done)
		else $error("segment sum finished without a square root result");

endmodule
